### rtl/jia_pkg.sv
package jia_pkg;

  // Restoring divider: one quotient bit per stage
  localparam int DivSteps = 64;

  localparam logic [4:0] ShiftMaskInt  = 5'h1F;
  localparam logic [5:0] ShiftMaskLong = 6'h3F;
  localparam logic [63:0] LowWord      = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_NEG,
    OP_SHL, OP_SHR, OP_USHR, OP_AND, OP_OR, OP_XOR
  } op_t;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        divide_by_zero;
  } rsp_t;

  // Classified item: operands already widened to 64 bits
  typedef struct packed {
    op_t         op;
    logic        known;
    logic        is_long;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  sh;
  } dec_t;

  // One slot of the execute pipeline
  typedef struct packed {
    logic        valid;
    op_t         op;
    logic        known;
    logic        is_long;
    logic        dz;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] res;
    logic [31:0] p_lh;
    logic [31:0] p_hl;
    logic [63:0] rem;
    logic [63:0] dq;
    logic [63:0] ub;
  } pipe_t;

endpackage

### rtl/jia_front.sv
module jia_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  jia_pkg::req_t req,
  output logic          dec_valid,
  input  logic          dec_ready,
  output jia_pkg::dec_t dec
);
  import jia_pkg::*;

  dec_t dec_next;

  // Classify the opcode and widen int operands
  always_comb begin
    dec_next.is_long = req.req_type[0];
    dec_next.known   = 1'b1;
    dec_next.op      = OP_ADD;
    unique case (req.req_type[4:1])
      4'd0:    dec_next.op = OP_ADD;
      4'd1:    dec_next.op = OP_SUB;
      4'd2:    dec_next.op = OP_MUL;
      4'd3:    dec_next.op = OP_DIV;
      4'd4:    dec_next.op = OP_REM;
      4'd5:    dec_next.op = OP_NEG;
      4'd6:    dec_next.op = OP_SHL;
      4'd7:    dec_next.op = OP_SHR;
      4'd8:    dec_next.op = OP_USHR;
      4'd9:    dec_next.op = OP_AND;
      4'd10:   dec_next.op = OP_OR;
      4'd11:   dec_next.op = OP_XOR;
      default: dec_next.known = 1'b0;
    endcase
    if (req.req_type[0]) begin
      dec_next.a  = req.operand_a;
      dec_next.b  = req.operand_b;
      dec_next.sh = req.operand_b[5:0] & ShiftMaskLong;
    end else begin
      dec_next.a  = {{32{req.operand_a[31]}}, req.operand_a[31:0]};
      dec_next.b  = {{32{req.operand_b[31]}}, req.operand_b[31:0]};
      dec_next.sh = {1'b0, req.operand_b[4:0] & ShiftMaskInt};
    end
  end

  assign req_ready = !dec_valid || dec_ready;

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (req_ready) begin
      dec_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      dec <= dec_next;
    end
  end

endmodule

### rtl/jia_queue.sv
module jia_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  jia_pkg::dec_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output jia_pkg::dec_t pop_data
);
  import jia_pkg::*;

  dec_t       mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != 2'd2) else $error("queue overflow");
`endif

endmodule

### rtl/jia_div_step.sv
module jia_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  jia_pkg::pipe_t s_in,
  output jia_pkg::pipe_t s_out
);
  import jia_pkg::*;

  logic [63:0] shifted;
  pipe_t       s_next;

  // Bring down one dividend bit and try to subtract the divisor
  always_comb begin
    s_next  = s_in;
    shifted = {s_in.rem[62:0], s_in.dq[63]};
    if (shifted >= s_in.ub) begin
      s_next.rem = shifted - s_in.ub;
      s_next.dq  = {s_in.dq[62:0], 1'b1};
    end else begin
      s_next.rem = shifted;
      s_next.dq  = {s_in.dq[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_out.valid <= 1'b0;
    end else if (en) begin
      s_out <= s_next;
    end
  end

endmodule

### rtl/jia_back.sv
module jia_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  jia_pkg::dec_t q_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output jia_pkg::rsp_t rsp
);
  import jia_pkg::*;

  logic  en;
  pipe_t pipe    [0:DivSteps];
  pipe_t step_in [0:DivSteps-1];
  pipe_t head_next;
  rsp_t  rsp_next;
  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] p_lh_full;
  logic [63:0] p_hl_full;
  logic [31:0] cross_sum;
  logic [63:0] fin;

  // Whole pipeline moves together when the output slot frees up
  assign en      = !rsp_valid || rsp_ready;
  assign q_ready = en;

  // Entry stage: simple results, multiply partials, divider setup
  always_comb begin
    ua = q_data.a[63] ? 64'd0 - q_data.a : q_data.a;
    ub = q_data.b[63] ? 64'd0 - q_data.b : q_data.b;
    p_lh_full = q_data.a[31:0] * q_data.b[63:32];
    p_hl_full = q_data.a[63:32] * q_data.b[31:0];
    head_next.valid   = q_valid;
    head_next.op      = q_data.op;
    head_next.known   = q_data.known;
    head_next.is_long = q_data.is_long;
    head_next.dz      = q_data.known && (q_data.op == OP_DIV || q_data.op == OP_REM)
                        && (q_data.b == 64'd0);
    head_next.neg_q   = q_data.a[63] ^ q_data.b[63];
    head_next.neg_r   = q_data.a[63];
    head_next.p_lh    = p_lh_full[31:0];
    head_next.p_hl    = p_hl_full[31:0];
    head_next.rem     = 64'd0;
    head_next.dq      = ua;
    head_next.ub      = ub;
    unique case (q_data.op)
      OP_ADD:  head_next.res = q_data.a + q_data.b;
      OP_SUB:  head_next.res = q_data.a - q_data.b;
      OP_MUL:  head_next.res = q_data.a[31:0] * q_data.b[31:0];
      OP_NEG:  head_next.res = 64'd0 - q_data.a;
      OP_SHL:  head_next.res = q_data.a << q_data.sh;
      OP_SHR:  head_next.res = 64'($signed(q_data.a) >>> q_data.sh);
      OP_USHR: head_next.res = q_data.is_long ? q_data.a >> q_data.sh
                                              : (q_data.a & LowWord) >> q_data.sh;
      OP_AND:  head_next.res = q_data.a & q_data.b;
      OP_OR:   head_next.res = q_data.a | q_data.b;
      OP_XOR:  head_next.res = q_data.a ^ q_data.b;
      default: head_next.res = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en) begin
      pipe[0] <= head_next;
    end
  end

  // Fold the multiply cross terms on the way into the first divider step
  always_comb begin
    cross_sum  = pipe[0].p_lh + pipe[0].p_hl;
    step_in[0] = pipe[0];
    if (pipe[0].op == OP_MUL) begin
      step_in[0].res = pipe[0].res + {cross_sum, 32'h0};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    if (k > 0) begin : g_link
      assign step_in[k] = pipe[k];
    end
    jia_div_step u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .s_in  (step_in[k]),
      .s_out (pipe[k+1])
    );
  end

  // Fix signs, pick the result and trim int forms
  always_comb begin
    fin = pipe[DivSteps].res;
    if (!pipe[DivSteps].known || pipe[DivSteps].dz) begin
      fin = 64'd0;
    end else if (pipe[DivSteps].op == OP_DIV) begin
      fin = pipe[DivSteps].neg_q ? 64'd0 - pipe[DivSteps].dq : pipe[DivSteps].dq;
    end else if (pipe[DivSteps].op == OP_REM) begin
      fin = pipe[DivSteps].neg_r ? 64'd0 - pipe[DivSteps].rem : pipe[DivSteps].rem;
    end
    rsp_next.result_value   = pipe[DivSteps].is_long ? fin : (fin & LowWord);
    rsp_next.divide_by_zero = pipe[DivSteps].dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= pipe[DivSteps].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTH
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.divide_by_zero |-> rsp.result_value == 64'd0)
    else $error("divide by zero with nonzero result");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe[DivSteps]))
    else $error("pipeline moved while stalled");
  a_dz_op: assert property (@(posedge clk) disable iff (rst)
    pipe[DivSteps].valid && pipe[DivSteps].dz
    |-> pipe[DivSteps].op == OP_DIV || pipe[DivSteps].op == OP_REM)
    else $error("zero divisor flag on a non-divide op");
`endif

endmodule

### rtl/jvm_integer_alu.sv
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_ready | req_type, operand_a, operand_b
// rsp      | out       | rsp_valid / rsp_ready | result_value, divide_by_zero
//
// One item per cycle sustained while rsp is not stalled. Every accepted item passes
// through the classify register, the queue, the entry stage, the 64-stage restoring
// divider and the output register before rsp_valid rises for it.
// Synchronous active-high reset empties every stage and the queue.
// A stalled rsp freezes the execute pipeline; the queue then fills and req_ready drops.
module jvm_integer_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  jia_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output jia_pkg::rsp_t rsp
);
  import jia_pkg::*;

  logic dec_valid;
  logic dec_ready;
  dec_t dec;
  logic q_valid;
  logic q_ready;
  dec_t q_data;

  jia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  jia_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_data  (dec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  jia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### verif/alu_checker.sv
`timescale 1ns / 1ps

module alu_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  jia_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  jia_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);
  import jia_pkg::*;

  rsp_t result_queue[$];

  // Truncating signed divide on 64-bit bit patterns; divisor nonzero
  function automatic void signed_divide(input logic [63:0] a, input logic [63:0] b,
                                        output logic [63:0] q, output logic [63:0] r);
    logic        na;
    logic        nb;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] uq;
    logic [63:0] ur;
    na = a[63];
    nb = b[63];
    ua = na ? -a : a;
    ub = nb ? -b : b;
    uq = ua / ub;
    ur = ua % ub;
    q = (na != nb) ? -uq : uq;
    r = na ? -ur : ur;
  endfunction

  function automatic rsp_t compute_result(req_t item);
    rsp_t        res;
    logic        is_long;
    logic [3:0]  opc;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] q;
    logic [63:0] r;
    logic [5:0]  sh;
    is_long = item.req_type[0];
    opc = item.req_type[4:1];
    a = item.operand_a;
    b = item.operand_b;
    res = '0;
    if (!is_long) begin
      a = {{32{a[31]}}, a[31:0]};
      b = {{32{b[31]}}, b[31:0]};
    end
    sh = is_long ? b[5:0] & ShiftMaskLong : {1'b0, b[4:0] & ShiftMaskInt};
    case (opc)
      OP_ADD:  res.result_value = a + b;
      OP_SUB:  res.result_value = a - b;
      OP_MUL:  res.result_value = a * b;
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          res.divide_by_zero = 1'b1;
        end else begin
          signed_divide(a, b, q, r);
          res.result_value = (opc == OP_DIV) ? q : r;
        end
      end
      OP_NEG:  res.result_value = -a;
      OP_SHL:  res.result_value = a << sh;
      OP_SHR:  res.result_value = $signed(a) >>> sh;
      OP_USHR: res.result_value = is_long ? a >> sh : (a & LowWord) >> sh;
      OP_AND:  res.result_value = a & b;
      OP_OR:   res.result_value = a | b;
      OP_XOR:  res.result_value = a ^ b;
      default: res.result_value = '0;
    endcase
    if (!is_long) res.result_value &= LowWord;
    return res;
  endfunction

  assign pending = result_queue.size();

  // Predict on accepted requests, compare on accepted responses
  always @(posedge clk) begin
    rsp_t exp_item;
    int   errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (req_valid && req_ready) result_queue.push_back(compute_result(req));
      if (rsp_valid && rsp_ready) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result item %h", rsp);
          errs++;
        end else begin
          exp_item = result_queue.pop_front();
          if (rsp.result_value !== exp_item.result_value) begin
            $error("result_value expected %h actual %h", exp_item.result_value,
                   rsp.result_value);
            errs++;
          end
          if (rsp.divide_by_zero !== exp_item.divide_by_zero) begin
            $error("divide_by_zero expected %b actual %b", exp_item.divide_by_zero,
                   rsp.divide_by_zero);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import jia_pkg::*;

  localparam int NumRandom = 1150;
  localparam int CycleLimit = 200000;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_ready;
  rsp_t  rsp;
  int    fail_count;
  int    pending;
  int    cycle_count = 0;
  req_t  directed_items[$];

  jvm_integer_alu u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  alu_checker u_checker (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Pick an operand that favors corner values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'h8000_0000_0000_0000;
      1: return '1;
      2: return '0;
      3: return {$urandom(), 32'h8000_0000};
      4: return {$urandom(), 32'hFFFF_FFFF};
      5: return {$urandom(), 32'h0000_0000};
      6: return 64'($urandom_range(0, 70));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Hold the item until accepted
  task automatic send_item(req_t item);
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk iff req_ready);
  endtask

  // Stall the receiver on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      case ((cycle_count / 300) % 3)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("jvm_integer_alu: mismatch");
      $finish;
    end
  end

  initial begin
    req_t item;
    int   burst;
    int   tail;
    int   gap;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: every opcode with edge operands, division corners
    for (int code = 0; code < 32; code += 2) begin
      item.req_type = 5'(code % 24 + (code / 24) * 24);
      if (code >= 24) item.req_type = 5'(code);
      item.operand_a = 64'h8000_0000_8000_0000;
      item.operand_b = '1;
      directed_items.push_back(item);
      item.req_type = item.req_type | 5'd1;
      item.operand_a = 64'h8000_0000_0000_0000;
      directed_items.push_back(item);
    end
    item = '{5'd6, 64'h7, 64'hFFFF_FFFF_0000_0000};
    directed_items.push_back(item);
    item = '{5'd7, 64'h7, 64'h0};
    directed_items.push_back(item);
    item = '{5'd9, 64'hFFFF_FFFF_FFFF_FFF9, 64'h2};
    directed_items.push_back(item);
    foreach (directed_items[i]) send_item(directed_items[i]);

    // Random bursts with gaps
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        item.req_type = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(24, 31))
                                                      : 5'($urandom_range(0, 23));
        item.operand_a = pick_operand();
        item.operand_b = pick_operand();
        send_item(item);
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    tail = 0;
    while (tail < 100) begin
      @(posedge clk);
      tail++;
    end
    if (fail_count == 0) begin
      $display("jvm_integer_alu: match");
    end else begin
      $display("jvm_integer_alu: mismatch");
    end
    $finish;
  end

endmodule
